// ===== sv/ebdf_pkg.sv =====
// Shared types and constants for the escaped byte deframer.
// Holds result kinds, configuration indexes, reset values and bundles.
// No dependencies.
package ebdf_pkg;

	localparam int BYTE_W = 8;
	localparam int LEN_W = 11;
	localparam int CFG_IDX_W = 2;

	typedef enum logic [1:0] {
		KIND_PAYLOAD = 2'd0,
		KIND_END = 2'd1,
		KIND_DROP = 2'd2
	} kind_t;

	localparam logic [CFG_IDX_W-1:0] CFG_ESC = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_START = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_END = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_LITERAL = 2'd3;

	localparam logic [BYTE_W-1:0] ESC_RESET = 8'd27;
	localparam logic [BYTE_W-1:0] START_RESET = 8'd1;
	localparam logic [BYTE_W-1:0] END_RESET = 8'd2;
	localparam logic [BYTE_W-1:0] LITERAL_RESET = 8'd3;

	typedef struct packed {
		logic [BYTE_W-1:0] esc_code;
		logic [BYTE_W-1:0] start_code;
		logic [BYTE_W-1:0] end_code;
		logic [BYTE_W-1:0] literal_code;
	} cfg_t;

	typedef struct packed {
		kind_t kind;
		logic [BYTE_W-1:0] payload;
		logic [LEN_W-1:0] frame_length;
	} result_t;

endpackage

// ===== sv/ebdf_core.sv =====
// Input register and frame state machine of the escaped byte deframer.
// Decodes one registered byte per cycle, unless stalled, against frame codes.
// Depends on ebdf_pkg.
module ebdf_core import ebdf_pkg::*; #(
	parameter int MAX_FRAME = 1024
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic [BYTE_W-1:0] rx_byte,
	input  cfg_t cfg,
	input  logic res_ready,
	output logic res_load,
	output result_t res
);

	localparam int CW = $clog2(MAX_FRAME + 1);
	localparam logic [CW-1:0] MAX_COUNT = CW'(MAX_FRAME);

	logic valid_s1;
	logic [BYTE_W-1:0] rx_byte_s1;
	logic in_frame_q, in_frame_d;
	logic esc_pend_q, esc_pend_d;
	logic [CW-1:0] count_q, count_d;
	logic emit;
	logic fire;
	logic accept;
	logic [CW+LEN_W-1:0] count_wide;

	assign count_wide = (CW + LEN_W)'(count_q);

	always_comb begin
		in_frame_d = in_frame_q;
		esc_pend_d = esc_pend_q;
		count_d = count_q;
		emit = 1'b0;
		res = '{kind: KIND_PAYLOAD, payload: '0, frame_length: '0};
		priority if (!in_frame_q && !esc_pend_q && rx_byte_s1 == cfg.esc_code) begin
			esc_pend_d = 1'b1;
		end else if (esc_pend_q && rx_byte_s1 == cfg.start_code) begin
			esc_pend_d = 1'b0;
			in_frame_d = 1'b1;
			count_d = '0;
			if (in_frame_q) begin
				emit = 1'b1;
				res.kind = KIND_DROP;
			end
		end else if (in_frame_q && !esc_pend_q && rx_byte_s1 == cfg.esc_code) begin
			esc_pend_d = 1'b1;
		end else if (in_frame_q && esc_pend_q && rx_byte_s1 == cfg.end_code) begin
			in_frame_d = 1'b0;
			esc_pend_d = 1'b0;
			count_d = '0;
			emit = 1'b1;
			res.kind = KIND_END;
			res.frame_length = count_wide[LEN_W-1:0];
		end else if (in_frame_q && (!esc_pend_q || rx_byte_s1 == cfg.literal_code)) begin
			// A payload byte that would pass the frame limit drops the frame.
			emit = 1'b1;
			esc_pend_d = 1'b0;
			if (count_q == MAX_COUNT) begin
				in_frame_d = 1'b0;
				count_d = '0;
				res.kind = KIND_DROP;
			end else begin
				count_d = count_q + 1'b1;
				res.kind = KIND_PAYLOAD;
				res.payload = esc_pend_q ? cfg.esc_code : rx_byte_s1;
			end
		end else if (in_frame_q || esc_pend_q) begin
			in_frame_d = 1'b0;
			esc_pend_d = 1'b0;
			count_d = '0;
			if (in_frame_q) begin
				emit = 1'b1;
				res.kind = KIND_DROP;
			end
		end else begin
			emit = 1'b0;
		end
	end

	assign fire = valid_s1 && (!emit || res_ready);
	assign res_load = fire && emit;
	assign in_stall = valid_s1 && !fire;
	assign accept = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			in_frame_q <= 1'b0;
			esc_pend_q <= 1'b0;
			count_q <= '0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (fire) begin
				valid_s1 <= 1'b0;
			end
			if (fire) begin
				in_frame_q <= in_frame_d;
				esc_pend_q <= esc_pend_d;
				count_q <= count_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rx_byte_s1 <= rx_byte;
		end
	end

endmodule

// ===== sv/ebdf_out_reg.sv =====
// Result register of the escaped byte deframer.
// Holds one result request until the receiver takes it.
// Depends on ebdf_pkg.
module ebdf_out_reg import ebdf_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic res_load,
	input  result_t res,
	output logic res_ready,
	output logic out_valid,
	input  logic out_stall,
	output result_t res_s2
);

	logic valid_s2;

	assign res_ready = !valid_s2 || !out_stall;
	assign out_valid = valid_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (res_load) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_s2 <= res;
		end
	end

endmodule

// ===== sv/escaped_byte_deframer_unit.sv =====
// Top level of the escaped byte deframer: frame code registers and the two stages.
// Depends on ebdf_pkg, ebdf_core and ebdf_out_reg.
//
// The block takes one received byte per clock while in_stall is low and recovers
// escape-delimited frames. Each payload byte comes out as its own request; a frame
// that closes cleanly yields an end request carrying its length, and a frame that is
// restarted, broken by a bad escape or longer than MAX_FRAME bytes yields a drop
// request. Every byte passes through the input register and its result through the
// output register, and the throughput is one byte per clock as long as the output
// side takes its requests. The frame codes should be written only while no byte is in
// flight.
module escaped_byte_deframer_unit import ebdf_pkg::*; #(
	parameter int MAX_FRAME = 1024
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [BYTE_W-1:0] cfg_data,
	input  logic in_valid,
	output logic in_stall,
	input  logic [BYTE_W-1:0] rx_byte,
	output logic out_valid,
	input  logic out_stall,
	output logic [1:0] kind,
	output logic [BYTE_W-1:0] payload,
	output logic [LEN_W-1:0] frame_length
);

	cfg_t cfg_q;
	logic res_ready;
	logic res_load;
	result_t res;
	result_t res_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{esc_code: ESC_RESET, start_code: START_RESET,
				end_code: END_RESET, literal_code: LITERAL_RESET};
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_ESC: cfg_q.esc_code <= cfg_data;
				CFG_START: cfg_q.start_code <= cfg_data;
				CFG_END: cfg_q.end_code <= cfg_data;
				CFG_LITERAL: cfg_q.literal_code <= cfg_data;
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	ebdf_core #(
		.MAX_FRAME(MAX_FRAME)
	) u_core (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.rx_byte(rx_byte),
		.cfg(cfg_q),
		.res_ready(res_ready),
		.res_load(res_load),
		.res(res)
	);

	ebdf_out_reg u_out_reg (
		.clk(clk),
		.arst_n(arst_n),
		.res_load(res_load),
		.res(res),
		.res_ready(res_ready),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.res_s2(res_s2)
	);

	assign kind = res_s2.kind;
	assign payload = res_s2.payload;
	assign frame_length = res_s2.frame_length;

endmodule

// ===== tb/sv/tb_escaped_byte_deframer_unit.sv =====
// Self-checking testbench for escaped_byte_deframer_unit: directed and random byte streams.
// Depends on ebdf_pkg and the deframer RTL; a built-in frame predictor supplies expected requests.
module tb_escaped_byte_deframer_unit;
	timeunit 1ns;
	timeprecision 1ps;
	import ebdf_pkg::*;

	localparam int FRAME_MAX = 1024;
	localparam int unsigned CYCLE_LIMIT = 1000000;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_wr_en;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [BYTE_W-1:0] cfg_data;
	logic in_valid;
	logic in_stall;
	logic [BYTE_W-1:0] rx_byte;
	logic out_valid;
	logic out_stall;
	logic [1:0] kind;
	logic [BYTE_W-1:0] payload;
	logic [LEN_W-1:0] frame_length;

	cfg_t codes = '{ESC_RESET, START_RESET, END_RESET, LITERAL_RESET};
	bit frame_open = 1'b0;
	bit esc_armed = 1'b0;
	int frame_bytes = 0;

	result_t pending_results[$];
	result_t due;
	bit quiet = 1'b0;
	int unsigned bytes_sent = 0;
	int unsigned code_sets = 1;
	int unsigned errors = 0;
	int unsigned cycles = 0;
	int unsigned n_payload = 0;
	int unsigned n_end = 0;
	int unsigned n_drop = 0;

	escaped_byte_deframer_unit #(
		.MAX_FRAME(FRAME_MAX)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.kind(kind),
		.payload(payload),
		.frame_length(frame_length)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic void close_frame();
		frame_open = 1'b0;
		esc_armed = 1'b0;
		frame_bytes = 0;
	endfunction

	function automatic bit take_payload(input logic [BYTE_W-1:0] value, inout result_t r);
		if (frame_bytes + 1 > FRAME_MAX) begin
			close_frame();
			r.kind = KIND_DROP;
			return 1'b1;
		end
		frame_bytes++;
		r.kind = KIND_PAYLOAD;
		r.payload = value;
		return 1'b1;
	endfunction

	function automatic bit deframe(input logic [BYTE_W-1:0] c, output result_t r);
		bit was_open;
		r.kind = KIND_PAYLOAD;
		r.payload = '0;
		r.frame_length = '0;
		was_open = frame_open;
		if (!frame_open && !esc_armed && c == codes.esc_code) begin
			esc_armed = 1'b1;
			return 1'b0;
		end
		if (esc_armed && c == codes.start_code) begin
			esc_armed = 1'b0;
			frame_open = 1'b1;
			frame_bytes = 0;
			r.kind = KIND_DROP;
			return was_open;
		end
		if (frame_open && !esc_armed && c == codes.esc_code) begin
			esc_armed = 1'b1;
			return 1'b0;
		end
		if (frame_open && esc_armed && c == codes.end_code) begin
			r.kind = KIND_END;
			r.frame_length = LEN_W'(frame_bytes);
			close_frame();
			return 1'b1;
		end
		if (frame_open && esc_armed && c == codes.literal_code) begin
			esc_armed = 1'b0;
			return take_payload(codes.esc_code, r);
		end
		if (frame_open && !esc_armed)
			return take_payload(c, r);
		if (frame_open || esc_armed) begin
			close_frame();
			r.kind = KIND_DROP;
			return was_open;
		end
		return 1'b0;
	endfunction

	task automatic send_byte(input logic [BYTE_W-1:0] b);
		result_t r;
		if (!quiet && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		do @(posedge clk); while (in_stall);
		if (deframe(b, r))
			pending_results.push_back(r);
		bytes_sent++;
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic load_codes(input cfg_t c);
		logic [CFG_IDX_W-1:0] regs [4];
		logic [BYTE_W-1:0] vals [4];
		regs = '{CFG_ESC, CFG_START, CFG_END, CFG_LITERAL};
		vals = '{c.esc_code, c.start_code, c.end_code, c.literal_code};
		for (int i = 0; i < 4; i++) begin
			cfg_wr_en <= 1'b1;
			cfg_index <= regs[i];
			cfg_data <= vals[i];
			@(posedge clk);
		end
		cfg_wr_en <= 1'b0;
		codes = c;
		code_sets++;
	endtask

	function automatic logic [BYTE_W-1:0] pick_byte();
		case ($urandom_range(0, 11))
			0: return codes.esc_code;
			1: return codes.start_code;
			2: return codes.end_code;
			3: return codes.literal_code;
			default: return BYTE_W'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic send_frame(input int unsigned len, input bit clean);
		logic [BYTE_W-1:0] b;
		send_byte(codes.esc_code);
		send_byte(codes.start_code);
		for (int unsigned i = 0; i < len; i++) begin
			b = pick_byte();
			if (b == codes.esc_code) begin
				send_byte(codes.esc_code);
				send_byte(codes.literal_code);
			end else begin
				send_byte(b);
			end
		end
		if (clean) begin
			send_byte(codes.esc_code);
			send_byte(codes.end_code);
		end else begin
			case ($urandom_range(0, 2))
				0: begin
					send_byte(codes.esc_code);
					send_byte(BYTE_W'($urandom_range(0, 255)));
				end
				1: ;
				default: begin
					send_byte(codes.esc_code);
					send_byte(codes.esc_code);
				end
			endcase
		end
	endtask

	task automatic random_traffic(input int unsigned n_bytes);
		int unsigned stop_at;
		stop_at = bytes_sent + n_bytes;
		while (bytes_sent < stop_at) begin
			case ($urandom_range(0, 9))
				0: send_byte(pick_byte());
				1: send_frame($urandom_range(0, 40), 1'b0);
				2: send_frame($urandom_range(0, 8), 1'b0);
				default: send_frame(($urandom_range(0, 3) == 0) ?
					$urandom_range(13, 80) : $urandom_range(0, 12), 1'b1);
			endcase
		end
	endtask

	task automatic test_directed_frames();
		logic [BYTE_W-1:0] seq [];
		seq = '{8'hFF,
			ESC_RESET, 8'h00,
			ESC_RESET, START_RESET, 8'h00, 8'hFF, ESC_RESET, LITERAL_RESET,
			ESC_RESET, END_RESET,
			ESC_RESET, START_RESET, ESC_RESET, END_RESET,
			ESC_RESET, START_RESET, 8'h55, ESC_RESET, START_RESET,
			8'hAA, ESC_RESET, 8'h77,
			ESC_RESET, START_RESET, START_RESET, ESC_RESET, ESC_RESET};
		foreach (seq[i])
			send_byte(seq[i]);
		wait_drained();
	endtask

	task automatic test_frame_overflow();
		logic [BYTE_W-1:0] b;
		send_byte(codes.esc_code);
		send_byte(codes.start_code);
		for (int i = 0; i <= FRAME_MAX; i++) begin
			b = BYTE_W'(i);
			if (b == codes.esc_code)
				b = ~codes.esc_code;
			send_byte(b);
		end
		send_byte(codes.esc_code);
		send_byte(codes.end_code);
		wait_drained();
	endtask

	task automatic test_code_settings();
		cfg_t sets [6];
		sets = '{'{8'hFF, 8'h00, 8'h80, 8'h7F},
			'{8'h00, 8'hFF, 8'hFE, 8'h01},
			'{8'h7E, 8'h7E, 8'h7E, 8'h7E},
			'{8'h55, 8'hAA, 8'hAA, 8'h33},
			'{8'h00, 8'h00, 8'h00, 8'h00},
			'{8'h00, 8'h00, 8'h00, 8'h00}};
		for (int i = 4; i < 6; i++)
			sets[i] = cfg_t'($urandom());
		foreach (sets[i]) begin
			wait_drained();
			load_codes(sets[i]);
			random_traffic(15);
		end
		wait_drained();
	endtask

	task automatic test_quiet_stream();
		load_codes('{ESC_RESET, START_RESET, END_RESET, LITERAL_RESET});
		quiet = 1'b1;
		random_traffic(50);
	endtask

	initial begin
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			repeat ($urandom_range(1, 24)) @(posedge clk);
			if (!quiet && $urandom_range(0, 2) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 16)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			case (kind)
				KIND_PAYLOAD: n_payload++;
				KIND_END: n_end++;
				default: n_drop++;
			endcase
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected request kind=%0d payload=%02h length=%0d",
					$time, kind, payload, frame_length);
				errors++;
			end else begin
				due = pending_results.pop_front();
				if (kind !== due.kind || payload !== due.payload ||
						frame_length !== due.frame_length) begin
					$display("%0t: mismatch expected kind=%0d payload=%02h length=%0d,",
						$time, due.kind, due.payload, due.frame_length);
					$display("%0t:          got kind=%0d payload=%02h length=%0d",
						$time, kind, payload, frame_length);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d requests outstanding", $time,
				pending_results.size());
			$display("tb_escaped_byte_deframer_unit NOT OK");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		rx_byte = '0;
		cfg_wr_en = 1'b0;
		cfg_index = CFG_ESC;
		cfg_data = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_frames();
		test_frame_overflow();
		test_code_settings();
		test_quiet_stream();
		wait_drained();
		repeat (4) @(posedge clk);
		$display("Sent %0d bytes under %0d code settings, with one frame past the limit.",
			bytes_sent, code_sets);
		$display("Checked %0d payload, %0d end and %0d drop requests with random stalls.",
			n_payload, n_end, n_drop);
		if (errors == 0)
			$display("tb_escaped_byte_deframer_unit OK");
		else
			$display("tb_escaped_byte_deframer_unit NOT OK");
		$finish;
	end

endmodule
